/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the queue block.
// Needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the next cycle edge, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

// Implication checked in the same cycle, disabled during reset.
`define ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`endif

/* hdl/cfpq_pkg.sv */
// Package of the class filtered priority queue: entry type, codes, widths.
// Used by every module of the block; depends on nothing.
package cfpq_pkg;
   localparam int DEPTH_DEFAULT = 16;
   localparam int KEY_W = 50;
   localparam int AGE_W = 12;
   localparam int RISK_W = 3;
   localparam int CAT_W = 2;
   localparam int CMD_W = 3;
   localparam int ST_W = 3;
   localparam int OCC_W = 5;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 4;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 12;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_EDIT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CALL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

   localparam logic [ST_W-1:0] ST_OK = 3'd0;
   localparam logic [ST_W-1:0] ST_LOW = 3'd1;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [ST_W-1:0] ST_SAME = 3'd3;
   localparam logic [ST_W-1:0] ST_FULL = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RISK = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEO_UPPER = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHILD_UPPER = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADULT_UPPER = 4'd3;

   localparam logic [RISK_W-1:0] MIN_RISK_RESET = 3'd2;
   localparam logic [AGE_W-1:0] NEO_UPPER_RESET = 12'd16;
   localparam logic [AGE_W-1:0] CHILD_UPPER_RESET = 12'd208;
   localparam logic [AGE_W-1:0] ADULT_UPPER_RESET = 12'd3200;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [AGE_W-1:0] age;
      logic [RISK_W-1:0] risk;
   } entry_type;
endpackage

/* hdl/class_filtered_priority_queue.sv */
// Channel  Direction  Transfer when
// req      in         req_tvalid && req_tready
// rsp      out        rsp_tvalid && rsp_tready
// csr      in         csr_valid && csr_ready (always ready)
// An item reads entries in turn (S_RD, S_CHK) until the search hits; an insert,
// edit, remove or call then moves the entries behind the hit one slot each
// (S_SHRD, S_SHWR). Reset is synchronous and clears the
// count, so the store needs no clearing pass. A waiting result does not block
// the next request; only its own completion waits for the result register.
// Depends on cfpq_pkg and cfpq_store.
module class_filtered_priority_queue #(
   parameter int DEPTH = cfpq_pkg::DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // key[49:0], age[61:50], risk[64:62], category[66:65], zero pad
   input logic [cfpq_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd[2:0]
   input logic [cfpq_pkg::CMD_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // key[49:0], age[61:50], risk[64:62], occupancy[69:65], zero pad
   output logic [cfpq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[2:0], found[3]
   output logic [cfpq_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic csr_valid,
   output logic csr_ready,
   input logic [cfpq_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [cfpq_pkg::CSR_DATA_W-1:0] csr_data
);
   import cfpq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RD = 7'b0000010,
      S_CHK = 7'b0000100,
      S_SHRD = 7'b0001000,
      S_SHWR = 7'b0010000,
      S_PUT = 7'b0100000,
      S_FIN = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      M_PLACE,
      M_KEY,
      M_AGE
   } mode_type;

   state_type state_ff, state_in;
   mode_type mode_ff, mode_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [AGE_W-1:0] age_ff, age_in;
   logic [RISK_W-1:0] risk_ff, risk_in;
   logic [CAT_W-1:0] cat_ff, cat_in;
   logic [CW-1:0] pos_ff, pos_in, j_ff, j_in, cnt_ff, cnt_in;
   logic up_ff, up_in, reins_ff, reins_in;
   logic [ST_W-1:0] st_ff, st_in;
   logic found_ff, found_in;
   entry_type out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic [RISK_W-1:0] min_risk_ff;
   logic [AGE_W-1:0] neo_ff, child_ff, adult_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;
   logic hit, finish_drop;
   logic [AGE_W-1:0] lo, hi;

   cfpq_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      case (cat_ff)
         2'd0: begin
            lo = '0;
            hi = neo_ff;
         end
         2'd1: begin
            lo = neo_ff;
            hi = child_ff;
         end
         default: begin
            lo = child_ff;
            hi = adult_ff;
         end
      endcase
      case (mode_ff)
         M_PLACE: hit = rd_data.risk < risk_ff;
         M_KEY: hit = rd_data.key == key_ff;
         default: hit = (rd_data.age >= lo) && (rd_data.age < hi);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      age_in = age_ff;
      risk_in = risk_ff;
      cat_in = cat_ff;
      pos_in = pos_ff;
      j_in = j_ff;
      cnt_in = cnt_ff;
      up_in = up_ff;
      reins_in = reins_ff;
      st_in = st_ff;
      found_in = found_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rd_addr = pos_ff[AW-1:0];
      wr_en = 1'b0;
      wr_addr = pos_ff[AW-1:0];
      wr_data = '{key: key_ff, age: age_ff, risk: risk_ff};
      finish_drop = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser;
               key_in = req_tdata[49:0];
               age_in = req_tdata[61:50];
               risk_in = req_tdata[64:62];
               cat_in = req_tdata[66:65];
               st_in = ST_OK;
               found_in = 1'b0;
               out_in = '0;
               reins_in = 1'b0;
               pos_in = '0;
               state_in = S_FIN;
               case (req_tuser)
                  CMD_INSERT: begin
                     mode_in = M_PLACE;
                     if (req_tdata[64:62] < min_risk_ff) begin
                        st_in = ST_LOW;
                     end else if (cnt_ff == FULL_CNT) begin
                        st_in = ST_FULL;
                     end else begin
                        state_in = (cnt_ff == '0) ? S_PUT : S_RD;
                     end
                  end
                  CMD_EDIT, CMD_REMOVE, CMD_CALL, CMD_QUERY: begin
                     mode_in = (req_tuser == CMD_EDIT || req_tuser == CMD_REMOVE) ?
                               M_KEY : M_AGE;
                     if (cnt_ff == '0) begin
                        st_in = ST_NOT_FOUND;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_RD: state_in = S_CHK;
         S_CHK: begin
            if (hit) begin
               case (mode_ff)
                  M_PLACE: begin
                     up_in = 1'b1;
                     j_in = cnt_ff - 1'b1;
                     state_in = S_SHRD;
                  end
                  M_KEY: begin
                     if (cmd_ff == CMD_EDIT && rd_data.risk == risk_ff) begin
                        st_in = ST_SAME;
                        state_in = S_FIN;
                     end else begin
                        if (cmd_ff == CMD_EDIT) begin
                           age_in = rd_data.age;
                           reins_in = risk_ff >= min_risk_ff;
                        end
                        finish_drop = (pos_ff + 1'b1) == cnt_ff;
                        up_in = 1'b0;
                        j_in = pos_ff + 1'b1;
                        state_in = S_SHRD;
                     end
                  end
                  default: begin
                     found_in = 1'b1;
                     out_in = rd_data;
                     if (cmd_ff == CMD_CALL) begin
                        finish_drop = (pos_ff + 1'b1) == cnt_ff;
                        up_in = 1'b0;
                        j_in = pos_ff + 1'b1;
                        state_in = S_SHRD;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
               endcase
            end else if ((pos_ff + 1'b1) == cnt_ff) begin
               if (mode_ff == M_PLACE) begin
                  pos_in = cnt_ff;
                  state_in = S_PUT;
               end else begin
                  st_in = ST_NOT_FOUND;
                  state_in = S_FIN;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_SHRD: begin
            rd_addr = j_ff[AW-1:0];
            state_in = S_SHWR;
         end
         S_SHWR: begin
            wr_en = 1'b1;
            wr_addr = up_ff ? AW'(j_ff + 1'b1) : AW'(j_ff - 1'b1);
            wr_data = rd_data;
            if (up_ff) begin
               if (j_ff == pos_ff) begin
                  state_in = S_PUT;
               end else begin
                  j_in = j_ff - 1'b1;
                  state_in = S_SHRD;
               end
            end else if (j_ff == cnt_ff - 1'b1) begin
               finish_drop = 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_SHRD;
            end
         end
         S_PUT: begin
            wr_en = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {2'b00, OCC_W'(cnt_ff), out_ff.risk, out_ff.age, out_ff.key};
               rsp_user_in = {found_ff, st_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (finish_drop) begin
         cnt_in = cnt_ff - 1'b1;
         if (reins_ff || reins_in) begin
            reins_in = 1'b0;
            mode_in = M_PLACE;
            pos_in = '0;
            state_in = (cnt_ff == CW'(1)) ? S_PUT : S_RD;
         end else begin
            state_in = S_FIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         reins_ff <= 1'b0;
         mode_ff <= M_PLACE;
         up_ff <= 1'b0;
         min_risk_ff <= MIN_RISK_RESET;
         neo_ff <= NEO_UPPER_RESET;
         child_ff <= CHILD_UPPER_RESET;
         adult_ff <= ADULT_UPPER_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         reins_ff <= reins_in;
         mode_ff <= mode_in;
         up_ff <= up_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MIN_RISK: min_risk_ff <= csr_data[RISK_W-1:0];
               CSR_NEO_UPPER: neo_ff <= csr_data[AGE_W-1:0];
               CSR_CHILD_UPPER: child_ff <= csr_data[AGE_W-1:0];
               CSR_ADULT_UPPER: adult_ff <= csr_data[AGE_W-1:0];
               default: ;
            endcase
         end
      end
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      age_ff <= age_in;
      risk_ff <= risk_in;
      cat_ff <= cat_in;
      pos_ff <= pos_in;
      j_ff <= j_in;
      st_ff <= st_in;
      found_ff <= found_in;
      out_ff <= out_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign csr_ready = 1'b1;
endmodule

/* hdl/cfpq_store.sv */
// Entry store of the queue: one write port, one read port, registered read data.
// Depends on cfpq_pkg for the entry type.
module cfpq_store #(
   parameter int DEPTH = cfpq_pkg::DEPTH_DEFAULT,
   parameter int AW = $clog2(DEPTH)
) (
   input logic clock,
   input logic wr_en,
   input logic [AW-1:0] wr_addr,
   input cfpq_pkg::entry_type wr_data,
   input logic [AW-1:0] rd_addr,
   output cfpq_pkg::entry_type rd_data
);
   import cfpq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/cfpq_checker.sv */
// Port level checks of the class filtered priority queue, bound to the top level.
// Depends on cfpq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cfpq_checker (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [cfpq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [cfpq_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import cfpq_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `ASSERT_SAME(a_found_ok, clock, reset, rsp_tvalid && rsp_tuser[3], rsp_tuser[2:0] == ST_OK)
   `ASSERT_SAME(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser[3], rsp_tdata[64:0] == '0)
endmodule

bind class_filtered_priority_queue cfpq_checker u_cfpq_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

/* test/class_filtered_priority_queue_chk.sv */
// Checker of the class filtered priority queue: watches request, response and
// register transfers, predicts each response and compares. Depends on cfpq_pkg.
`timescale 1ns / 100ps
module class_filtered_priority_queue_chk
   import cfpq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [CMD_W-1:0] req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic csr_valid,
   input logic csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0] csr_data,
   output int fail_count,
   output int pending
);
   typedef struct packed {
      logic [ST_W-1:0] status;
      logic found;
      logic [KEY_W-1:0] key;
      logic [AGE_W-1:0] age;
      logic [RISK_W-1:0] risk;
      logic [OCC_W-1:0] occ;
   } reply_type;

   entry_type queue_store[DEPTH];
   int count;
   logic [RISK_W-1:0] min_risk;
   logic [AGE_W-1:0] neo_upper, child_upper, adult_upper;
   reply_type reply_queue[$];

   function automatic void drop_at(int pos);
      for (int i = pos; i + 1 < count; i++) queue_store[i] = queue_store[i + 1];
      count--;
   endfunction

   function automatic logic [ST_W-1:0] place(entry_type e);
      int pos;
      pos = 0;
      if (e.risk < min_risk) return ST_LOW;
      if (count >= DEPTH) return ST_FULL;
      while (pos < count && queue_store[pos].risk >= e.risk) pos++;
      for (int i = count; i > pos; i--) queue_store[i] = queue_store[i - 1];
      queue_store[pos] = e;
      count++;
      return ST_OK;
   endfunction

   function automatic reply_type serve_request(logic [CMD_W-1:0] cmd,
                                               logic [REQ_DATA_W-1:0] data);
      reply_type r;
      entry_type e;
      logic [CAT_W-1:0] cat;
      logic [AGE_W-1:0] lo, hi;
      logic [ST_W-1:0] dummy;
      int pos;
      r = '0;
      e.key = data[49:0];
      e.age = data[61:50];
      e.risk = data[64:62];
      cat = data[66:65];
      r.status = ST_OK;
      pos = 0;
      if (cmd == CMD_INSERT) begin
         r.status = place(e);
      end else if (cmd == CMD_EDIT || cmd == CMD_REMOVE) begin
         while (pos < count && queue_store[pos].key != e.key) pos++;
         if (pos >= count) begin
            r.status = ST_NOT_FOUND;
         end else if (cmd == CMD_REMOVE) begin
            drop_at(pos);
         end else if (queue_store[pos].risk == e.risk) begin
            r.status = ST_SAME;
         end else begin
            e.age = queue_store[pos].age;
            drop_at(pos);
            dummy = place(e);
         end
      end else if (cmd == CMD_CALL || cmd == CMD_QUERY) begin
         if (cat == 0) begin
            lo = '0;
            hi = neo_upper;
         end else if (cat == 1) begin
            lo = neo_upper;
            hi = child_upper;
         end else begin
            lo = child_upper;
            hi = adult_upper;
         end
         while (pos < count && !(queue_store[pos].age >= lo && queue_store[pos].age < hi))
            pos++;
         if (pos >= count) begin
            r.status = ST_NOT_FOUND;
         end else begin
            r.found = 1'b1;
            r.key = queue_store[pos].key;
            r.age = queue_store[pos].age;
            r.risk = queue_store[pos].risk;
            if (cmd == CMD_CALL) drop_at(pos);
         end
      end
      r.occ = count[OCC_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want, got;
      if (reset) begin
         count = 0;
         min_risk = MIN_RISK_RESET;
         neo_upper = NEO_UPPER_RESET;
         child_upper = CHILD_UPPER_RESET;
         adult_upper = ADULT_UPPER_RESET;
         reply_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_RISK: min_risk = csr_data[RISK_W-1:0];
               CSR_NEO_UPPER: neo_upper = csr_data;
               CSR_CHILD_UPPER: child_upper = csr_data;
               CSR_ADULT_UPPER: adult_upper = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) reply_queue.push_back(serve_request(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser[2:0];
            got.found = rsp_tuser[3];
            got.key = rsp_tdata[49:0];
            got.age = rsp_tdata[61:50];
            got.risk = rsp_tdata[64:62];
            got.occ = rsp_tdata[69:65];
            if (reply_queue.size() == 0) begin
               $error("response transfer with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = reply_queue.pop_front();
               if (got != want) begin
                  if (got.status != want.status)
                     $error("status: expected %0d, got %0d", want.status, got.status);
                  if (got.found != want.found)
                     $error("found: expected %0d, got %0d", want.found, got.found);
                  if (got.key != want.key)
                     $error("key_out: expected %0d, got %0d", want.key, got.key);
                  if (got.age != want.age)
                     $error("age_out: expected %0d, got %0d", want.age, got.age);
                  if (got.risk != want.risk)
                     $error("risk_out: expected %0d, got %0d", want.risk, got.risk);
                  if (got.occ != want.occ)
                     $error("occupancy: expected %0d, got %0d", want.occ, got.occ);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending = reply_queue.size();
   end
endmodule

/* test/class_filtered_priority_queue_tb.sv */
// Top of the queue testbench: clock, reset, request and register stimulus and
// the verdict. Depends on cfpq_pkg, the block and class_filtered_priority_queue_chk.
`timescale 1ns / 100ps
module class_filtered_priority_queue_tb;
   import cfpq_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 4'd9;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int fail_count, pending;
   int cycles = 0;
   bit quiet = 1'b0;
   bit hold_off = 1'b0;
   logic [KEY_W-1:0] key_pool[8];

   always #10 clock = ~clock;

   class_filtered_priority_queue DUT (.*);
   class_filtered_priority_queue_chk checker_inst (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: random stalls, a long hold-off on request, none at the end.
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   task automatic send_item(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                            logic [AGE_W-1:0] age, logic [RISK_W-1:0] risk,
                            logic [CAT_W-1:0] cat);
      req_tuser <= cmd;
      req_tdata <= {5'b0, cat, risk, age, key};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4 * DEPTH_DEFAULT + 8) @(negedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      logic [KEY_W-1:0] key;
      logic [AGE_W-1:0] age;
      logic [RISK_W-1:0] risk;
      logic [CAT_W-1:0] cat;
      logic [CMD_W-1:0] cmd;
      int pick;
      pick = $urandom_range(0, 99);
      key = (pick < 85) ? key_pool[$urandom_range(0, 7)] : KEY_W'({$urandom, $urandom});
      age = AGE_W'($urandom);
      risk = RISK_W'($urandom);
      cat = CAT_W'($urandom);
      if (pick < 40)
         cmd = CMD_INSERT;
      else if (pick < 55)
         cmd = CMD_EDIT;
      else if (pick < 65)
         cmd = CMD_REMOVE;
      else if (pick < 82)
         cmd = CMD_CALL;
      else if (pick < 97)
         cmd = CMD_QUERY;
      else
         cmd = CMD_W'($urandom_range(5, 7));
      send_item(cmd, key, age, risk, cat);
   endtask

   initial begin
      for (int i = 0; i < 8; i++) key_pool[i] = KEY_W'({$urandom, $urandom});
      key_pool[0] = '0;
      key_pool[1] = 50'd999999999999999;
      key_pool[2] = '1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // Directed part: field extremes, every command and the special cases.
      send_item(CMD_INSERT, key_pool[0], 12'd0, 3'd7, 2'd0);
      send_item(CMD_INSERT, key_pool[1], 12'd4095, 3'd2, 2'd0);
      send_item(CMD_INSERT, key_pool[2], 12'd100, 3'd1, 2'd0);
      send_item(CMD_INSERT, key_pool[2], 12'd100, 3'd2, 2'd0);
      send_item(CMD_INSERT, key_pool[2], 12'd100, 3'd7, 2'd0);
      send_item(CMD_EDIT, key_pool[2], 12'd0, 3'd2, 2'd0);
      send_item(CMD_EDIT, key_pool[2], 12'd0, 3'd2, 2'd0);
      send_item(CMD_EDIT, key_pool[3], 12'd0, 3'd5, 2'd0);
      send_item(CMD_EDIT, key_pool[1], 12'd0, 3'd0, 2'd0);
      send_item(CMD_QUERY, '0, 12'd0, 3'd0, 2'd0);
      send_item(CMD_QUERY, '0, 12'd0, 3'd0, 2'd1);
      send_item(CMD_CALL, '0, 12'd0, 3'd0, 2'd3);
      send_item(CMD_CALL, '0, 12'd0, 3'd0, 2'd2);
      send_item(CMD_REMOVE, key_pool[4], 12'd0, 3'd0, 2'd0);
      send_item(CMD_REMOVE, key_pool[2], 12'd0, 3'd0, 2'd0);
      send_item(CMD_SPARE, '1, '1, '1, 2'd3);
      for (int i = 0; i < 17; i++)
         send_item(CMD_INSERT, KEY_W'({$urandom, $urandom}), AGE_W'($urandom), 3'd5, 2'd0);
      send_item(CMD_INSERT, '0, 12'd0, 3'd0, 2'd0);
      // Long receiver hold-off while requests keep coming.
      hold_off = 1'b1;
      for (int i = 0; i < 40; i++) random_item();
      // Random phases under several register settings.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_reg(CSR_MIN_RISK, 12'd0);
            1: begin
               write_reg(CSR_MIN_RISK, 12'd7);
               write_reg(CSR_NEO_UPPER, 12'd0);
            end
            2: begin
               write_reg(CSR_MIN_RISK, CSR_DATA_W'($urandom_range(0, 7)));
               write_reg(CSR_NEO_UPPER, 12'd4095);
               write_reg(CSR_CHILD_UPPER, 12'd0);
               write_reg(CSR_ADULT_UPPER, 12'd4095);
            end
            3: begin
               write_reg(CSR_NEO_UPPER, 12'd1000);
               write_reg(CSR_CHILD_UPPER, 12'd2000);
               write_reg(CSR_ADULT_UPPER, 12'd0);
               write_reg(CSR_SPARE, 12'd5);
            end
            4: begin
               write_reg(CSR_MIN_RISK, 12'd1);
               write_reg(CSR_NEO_UPPER, CSR_DATA_W'($urandom));
               write_reg(CSR_CHILD_UPPER, CSR_DATA_W'($urandom));
               write_reg(CSR_ADULT_UPPER, 12'd4095);
            end
            default: begin
               write_reg(CSR_MIN_RISK, 12'd2);
               write_reg(CSR_NEO_UPPER, 12'd16);
               write_reg(CSR_CHILD_UPPER, 12'd208);
               write_reg(CSR_ADULT_UPPER, 12'd3200);
               quiet = 1'b1;
            end
         endcase
         for (int i = 0; i < 210; i++) random_item();
      end
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hdl
hdl/cfpq_pkg.sv
hdl/cfpq_store.sv
hdl/class_filtered_priority_queue.sv
hdl/cfpq_checker.sv
test/class_filtered_priority_queue_chk.sv
test/class_filtered_priority_queue_tb.sv
